[src/tunp_pkg.sv]
package tunp_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int COUNT_BITS_DEF = 16;
  localparam int RADIX_BITS     = 6;
  localparam int BYTE_BITS      = 8;

  localparam logic [BYTE_BITS-1:0] CH_NUL     = 8'h00;
  localparam logic [BYTE_BITS-1:0] CH_TAB     = 8'h09;
  localparam logic [BYTE_BITS-1:0] CH_CR      = 8'h0d;
  localparam logic [BYTE_BITS-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_BITS-1:0] CH_PLUS    = 8'h2b;
  localparam logic [BYTE_BITS-1:0] CH_MINUS   = 8'h2d;
  localparam logic [BYTE_BITS-1:0] CH_ZERO    = 8'h30;
  localparam logic [BYTE_BITS-1:0] CH_NINE    = 8'h39;
  localparam logic [BYTE_BITS-1:0] CH_UPPER_A = 8'h41;
  localparam logic [BYTE_BITS-1:0] CH_UPPER_X = 8'h58;
  localparam logic [BYTE_BITS-1:0] CH_LOWER_A = 8'h61;
  localparam logic [BYTE_BITS-1:0] CH_LOWER_X = 8'h78;
  localparam logic [BYTE_BITS-1:0] DIGIT_NONE = 8'hff;
  localparam logic [BYTE_BITS-1:0] DIGIT_TEN  = 8'd10;

  localparam logic [RADIX_BITS-1:0] RADIX_AUTO = 6'd0;
  localparam logic [RADIX_BITS-1:0] RADIX_OCT  = 6'd8;
  localparam logic [RADIX_BITS-1:0] RADIX_DEC  = 6'd10;
  localparam logic [RADIX_BITS-1:0] RADIX_HEX  = 6'd16;

  typedef struct packed {
    logic                 valid;
    logic [BYTE_BITS-1:0] text_byte;
  } byte_word_t;

  function automatic logic is_space(input logic [BYTE_BITS-1:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  // letters map from ten upward, digits wrap below '0'
  function automatic logic [BYTE_BITS-1:0] digit_of(input logic [BYTE_BITS-1:0] b);
    logic [BYTE_BITS-1:0] d;
    if (b >= CH_LOWER_A) begin
      d = b - CH_LOWER_A + DIGIT_TEN;
    end else if (b >= CH_UPPER_A) begin
      d = b - CH_UPPER_A + DIGIT_TEN;
    end else if (b <= CH_NINE) begin
      d = b - CH_ZERO;
    end else begin
      d = DIGIT_NONE;
    end
    return d;
  endfunction

endpackage

[src/tunp_in_stage.sv]
module tunp_in_stage (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [tunp_pkg::BYTE_BITS-1:0]   in_text_byte,
  input  logic                             take,
  output tunp_pkg::byte_word_t             word
);

  logic                           valid_r;
  logic                           valid_nxt;
  logic [tunp_pkg::BYTE_BITS-1:0] byte_r;
  logic                           accept;

  // hold the word until the parser takes it
  assign in_stall  = valid_r && !take;
  assign accept    = in_valid && !in_stall;
  assign valid_nxt = accept ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (accept) begin
      byte_r <= in_text_byte;
    end
  end

  assign word.valid     = valid_r;
  assign word.text_byte = byte_r;

endmodule

[src/tunp_core.sv]
module tunp_core #(
  parameter int VALUE_BITS = tunp_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS = tunp_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tunp_pkg::byte_word_t              word,
  output logic                              take,
  input  logic [tunp_pkg::RADIX_BITS-1:0]   radix,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [VALUE_BITS-1:0]             out_parsed_value,
  output logic                              out_range_error,
  output logic [COUNT_BITS-1:0]             out_consumed_count
);

  localparam int PROD_W = VALUE_BITS + tunp_pkg::RADIX_BITS;
  localparam int SUM_W  = PROD_W + 1;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_PLUS,
    PH_PREFIX,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  phase_t                          ph_r, ph_nxt;
  logic [VALUE_BITS-1:0]           acc_r, acc_nxt;
  logic                            minus_r, minus_nxt;
  logic [tunp_pkg::RADIX_BITS-1:0] arad_r, arad_nxt;
  logic [COUNT_BITS-1:0]           pos_r, pos_nxt;
  logic                            ovf_r, ovf_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0]           value_r, value_nxt;
  logic                            range_r, range_nxt;
  logic [COUNT_BITS-1:0]           count_r, count_nxt;

  logic [tunp_pkg::BYTE_BITS-1:0]  b;
  logic [tunp_pkg::BYTE_BITS-1:0]  d;
  logic                            is_nul;
  logic                            prefix_path;
  logic                            do_digit;
  logic [tunp_pkg::RADIX_BITS-1:0] base_sel;
  logic [COUNT_BITS-1:0]           pos_pre;
  logic [PROD_W-1:0]               prod;
  logic [SUM_W-1:0]                sum;
  logic                            digit_ovf;
  logic                            load_out;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] p);
    return (p == {COUNT_BITS{1'b1}}) ? p : p + COUNT_BITS'(1);
  endfunction

  assign b        = word.text_byte;
  assign d        = tunp_pkg::digit_of(b);
  assign is_nul   = (b == tunp_pkg::CH_NUL);
  // a terminator needs a free output register, other bytes go straight in
  assign take     = word.valid && (!is_nul || !out_valid_r || !out_stall);
  assign load_out = take && is_nul;

  always_comb begin
    ph_nxt      = ph_r;
    acc_nxt     = acc_r;
    minus_nxt   = minus_r;
    arad_nxt    = arad_r;
    pos_nxt     = pos_r;
    ovf_nxt     = ovf_r;
    prefix_path = 1'b0;
    do_digit    = 1'b0;
    base_sel    = arad_r;
    pos_pre     = pos_r;

    case (ph_r)
      PH_SPACE: begin
        if (tunp_pkg::is_space(b)) begin
          pos_nxt = sat_inc(pos_r);
        end else if (b == tunp_pkg::CH_MINUS) begin
          minus_nxt = 1'b1;
          pos_nxt   = sat_inc(pos_r);
          ph_nxt    = PH_PLUS;
        end else if (b == tunp_pkg::CH_PLUS) begin
          pos_nxt = sat_inc(pos_r);
          ph_nxt  = PH_PREFIX;
        end else begin
          prefix_path = 1'b1;
        end
      end
      PH_PLUS: begin
        if (b == tunp_pkg::CH_PLUS) begin
          pos_nxt = sat_inc(pos_r);
          ph_nxt  = PH_PREFIX;
        end else begin
          prefix_path = 1'b1;
        end
      end
      PH_PREFIX: begin
        prefix_path = 1'b1;
      end
      PH_ZERO: begin
        if ((b == tunp_pkg::CH_LOWER_X) || (b == tunp_pkg::CH_UPPER_X)) begin
          pos_nxt  = sat_inc(sat_inc(pos_r));
          arad_nxt = tunp_pkg::RADIX_HEX;
          ph_nxt   = PH_DIGITS;
        end else begin
          // the held-back zero counts as a digit, then this byte is parsed
          pos_pre  = sat_inc(pos_r);
          pos_nxt  = pos_pre;
          ph_nxt   = PH_DIGITS;
          do_digit = 1'b1;
        end
      end
      PH_DIGITS: begin
        do_digit = 1'b1;
      end
      default: begin
      end
    endcase

    if (prefix_path) begin
      if (((radix == tunp_pkg::RADIX_AUTO) || (radix == tunp_pkg::RADIX_HEX)) &&
          (b == tunp_pkg::CH_ZERO)) begin
        arad_nxt = (radix == tunp_pkg::RADIX_AUTO) ? tunp_pkg::RADIX_OCT
                                                   : tunp_pkg::RADIX_HEX;
        ph_nxt   = PH_ZERO;
      end else begin
        base_sel = (radix == tunp_pkg::RADIX_AUTO) ? tunp_pkg::RADIX_DEC : radix;
        arad_nxt = base_sel;
        ph_nxt   = PH_DIGITS;
        do_digit = 1'b1;
      end
    end

    prod      = PROD_W'(acc_r) * PROD_W'(base_sel);
    sum       = SUM_W'(prod) + SUM_W'(d[tunp_pkg::RADIX_BITS-1:0]);
    digit_ovf = |sum[SUM_W-1:VALUE_BITS];

    if (do_digit) begin
      if (d >= {2'b00, base_sel}) begin
        ph_nxt = PH_DONE;
      end else if (digit_ovf) begin
        ovf_nxt = 1'b1;
        ph_nxt  = PH_DONE;
      end else begin
        acc_nxt = sum[VALUE_BITS-1:0];
        pos_nxt = sat_inc(pos_pre);
        ph_nxt  = PH_DIGITS;
      end
    end

    // result word from the state before the terminator
    if (ovf_r) begin
      value_nxt = {VALUE_BITS{1'b1}};
    end else if (minus_r) begin
      value_nxt = VALUE_BITS'(0) - acc_r;
    end else begin
      value_nxt = acc_r;
    end
    range_nxt = ovf_r;
    count_nxt = (ph_r == PH_ZERO) ? sat_inc(pos_r) : pos_r;

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= PH_SPACE;
      acc_r       <= '0;
      minus_r     <= 1'b0;
      arad_r      <= '0;
      pos_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (load_out) begin
        ph_r    <= PH_SPACE;
        acc_r   <= '0;
        minus_r <= 1'b0;
        arad_r  <= '0;
        pos_r   <= '0;
        ovf_r   <= 1'b0;
      end else if (take) begin
        ph_r    <= ph_nxt;
        acc_r   <= acc_nxt;
        minus_r <= minus_nxt;
        arad_r  <= arad_nxt;
        pos_r   <= pos_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
    if (load_out) begin
      value_r <= value_nxt;
      range_r <= range_nxt;
      count_r <= count_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_parsed_value   = value_r;
  assign out_range_error    = range_r;
  assign out_consumed_count = count_r;

endmodule

[src/text_to_unsigned_number_parser.sv]
// Streaming text-to-unsigned-number parser.
// Input channel: one string byte per word on in_text_byte (in_valid/in_stall),
// the terminating zero byte included. Leading whitespace, an optional '-'
// then '+', and a radix prefix are consumed before the digits.
// Result channel: one word per zero byte on out_parsed_value, out_range_error
// and out_consumed_count (out_valid/out_stall); other bytes give no word.
// Configuration: cfg_wr_en/cfg_wr_data write the radix (0 = detect from
// prefix); write it only between strings.
// Throughput: one byte per cycle while no zero byte waits on a held result,
// with the multiply-by-radix and add done combinationally in the parse stage.
// A zero byte passes the input register, then its word loads the result register.
// While out_stall holds a result, non-zero bytes of the next string still
// flow; a zero byte waits in the input register and in_stall rises.
// Reset (synchronous, rst_n low) clears the parse state, the radix to 0 and
// drops any pending words.
module text_to_unsigned_number_parser #(
  parameter int VALUE_BITS = tunp_pkg::VALUE_BITS_DEF,
  parameter int COUNT_BITS = tunp_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tunp_pkg::BYTE_BITS-1:0]  in_text_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [VALUE_BITS-1:0]           out_parsed_value,
  output logic                            out_range_error,
  output logic [COUNT_BITS-1:0]           out_consumed_count,
  input  logic                            cfg_wr_en,
  input  logic [tunp_pkg::RADIX_BITS-1:0] cfg_wr_data
);

  tunp_pkg::byte_word_t            word;
  logic                            take;
  logic [tunp_pkg::RADIX_BITS-1:0] radix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= tunp_pkg::RADIX_AUTO;
    end else if (cfg_wr_en) begin
      radix_r <= cfg_wr_data;
    end
  end

  tunp_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_text_byte (in_text_byte),
    .take         (take),
    .word         (word)
  );

  tunp_core #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .word               (word),
    .take               (take),
    .radix              (radix_r),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_parsed_value   (out_parsed_value),
    .out_range_error    (out_range_error),
    .out_consumed_count (out_consumed_count)
  );

endmodule
